### sv/m4vt_pkg.sv
// Shared types and constants for the 4x4 matrix-vector transform engine.
// Used by the channel interfaces and by every module of the block.
package m4vt_pkg;

    localparam int DIM        = 4;
    localparam int FRAC_BITS  = 16;
    localparam int DATA_W     = 32;
    localparam int CFG_W      = 2 * DATA_W;
    localparam int NUM_REGS   = DIM * DIM / 2;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int LANE_IDX_W = $clog2(DIM);
    localparam int PAIRS      = DIM / 2;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int PAIR_W     = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 2;

    localparam logic [DATA_W-1:0] COEF_ONE = DATA_W'(1) << FRAC_BITS;
    localparam logic [DATA_W-1:0] SAT_POS  = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_NEG  = {1'b1, {(DATA_W - 1){1'b0}}};

    typedef logic signed [DATA_W-1:0] word_t;
    typedef word_t [DIM-1:0]          vec_t;
    typedef vec_t [DIM-1:0]           mat_t;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef prod_t [DIM-1:0]          prod_row_t;
    typedef prod_row_t [DIM-1:0]      prod_mat_t;

    typedef logic signed [PAIR_W-1:0] pair_t;
    typedef pair_t [PAIRS-1:0]        pair_row_t;
    typedef pair_row_t [DIM-1:0]      pair_mat_t;

    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef sum_t [DIM-1:0]           sum_vec_t;

    typedef struct packed {
        vec_t lanes;
        logic saturated;
    } res_t;

endpackage

### sv/m4vt_vec_if.sv
// Input channel of the transform engine: one Q16.16 4-vector per transfer.
// Depends on m4vt_pkg.
interface m4vt_vec_if
    import m4vt_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t vec_x;
    word_t vec_y;
    word_t vec_z;
    word_t vec_w;

    modport source (output valid, output vec_x, output vec_y, output vec_z, output vec_w,
                    input ready);
    modport sink (input valid, input vec_x, input vec_y, input vec_z, input vec_w,
                  output ready);
endinterface

### sv/m4vt_res_if.sv
// Result channel of the transform engine: one transformed vector per transfer.
// Depends on m4vt_pkg.
interface m4vt_res_if
    import m4vt_pkg::*;
();
    logic  valid;
    logic  ready;
    word_t out_x;
    word_t out_y;
    word_t out_z;
    word_t out_w;
    logic  saturated;

    modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                    output saturated, input ready);
    modport sink (input valid, input out_x, input out_y, input out_z, input out_w,
                  input saturated, output ready);
endinterface

### sv/matrix4_vector_transform_top.sv
// Top level of the 4x4 matrix-vector transform engine.
// Depends on m4vt_pkg, m4vt_vec_if, m4vt_res_if and the m4vt stage modules.
//
// The engine accepts one Q16.16 vector per clock while the result is not stalled and
// returns M * v, sustaining one vector per cycle through a four-stage pipeline:
// multiply, two adder levels, then truncation and saturation into the output
// register. A stalled result holds the pipeline without loss; bubbles are squeezed
// out. The matrix resets to identity and is written two coefficients per register;
// the user must write it only while the pipeline is empty, as the block does not enforce this.
module matrix4_vector_transform_top
    import m4vt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    m4vt_vec_if.sink             vec,
    m4vt_res_if.source           res
);

    mat_t      mat;
    vec_t      vec_in;
    prod_mat_t prod;
    sum_vec_t  sums;
    res_t      result;
    logic      mul_valid;
    logic      mul_ready;
    logic      sum_valid;
    logic      sum_ready;

    assign vec_in[0] = vec.vec_x;
    assign vec_in[1] = vec.vec_y;
    assign vec_in[2] = vec.vec_z;
    assign vec_in[3] = vec.vec_w;

    m4vt_coef_regs u_coef_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mat       (mat)
    );

    m4vt_mul_stage u_mul_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vec.valid),
        .in_ready  (vec.ready),
        .vec       (vec_in),
        .mat       (mat),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .prod      (prod)
    );

    m4vt_sum_stage u_sum_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .prod      (prod),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .sums      (sums)
    );

    m4vt_sat_stage u_sat_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .sums      (sums),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .res       (result)
    );

    assign res.out_x     = result.lanes[0];
    assign res.out_y     = result.lanes[1];
    assign res.out_z     = result.lanes[2];
    assign res.out_w     = result.lanes[3];
    assign res.saturated = result.saturated;

endmodule

### sv/m4vt_coef_regs.sv
// Matrix coefficient registers with the write port; reset loads the identity.
// Depends on m4vt_pkg.
module m4vt_coef_regs
    import m4vt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output mat_t                 mat
);

    mat_t                  mat_reg;
    logic [LANE_IDX_W-1:0] row_sel;
    logic [LANE_IDX_W-1:0] col_lo;
    logic [LANE_IDX_W-1:0] col_hi;

    assign row_sel = cfg_index[REG_IDX_W-1:1];
    assign col_lo  = {cfg_index[0], 1'b0};
    assign col_hi  = {cfg_index[0], 1'b1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < DIM; r++)
            begin
                for (int c = 0; c < DIM; c++)
                begin
                    mat_reg[r][c] <= (r == c) ? COEF_ONE : '0;
                end
            end
        end
        else if (cfg_we)
        begin
            mat_reg[row_sel][col_lo] <= cfg_data[DATA_W-1:0];
            mat_reg[row_sel][col_hi] <= cfg_data[CFG_W-1:DATA_W];
        end
    end

    assign mat = mat_reg;

endmodule

### sv/m4vt_mul_stage.sv
// First pipeline stage: the sixteen coefficient-by-element products, registered.
// Depends on m4vt_pkg.
module m4vt_mul_stage
    import m4vt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  vec_t      vec,
    input  mat_t      mat,
    output logic      out_valid,
    input  logic      out_ready,
    output prod_mat_t prod
);

    logic      valid_reg;
    prod_mat_t prod_reg;
    prod_mat_t prod_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                prod_next[r][c] = $signed(mat[r][c]) * $signed(vec[c]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = valid_reg;
    assign prod      = prod_reg;

endmodule

### sv/m4vt_sum_stage.sv
// Second and third pipeline stages: a registered two-level adder tree per row.
// Depends on m4vt_pkg.
module m4vt_sum_stage
    import m4vt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  prod_mat_t prod,
    output logic      out_valid,
    input  logic      out_ready,
    output sum_vec_t  sums
);

    logic      pair_valid_reg;
    logic      sum_valid_reg;
    logic      sum_ready;
    pair_mat_t pair_reg;
    pair_mat_t pair_next;
    sum_vec_t  sum_reg;
    sum_vec_t  sum_next;

    assign sum_ready = !sum_valid_reg || out_ready;
    assign in_ready  = !pair_valid_reg || sum_ready;

    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            for (int k = 0; k < PAIRS; k++)
            begin
                pair_next[r][k] = PAIR_W'($signed(prod[r][2 * k]))
                                + PAIR_W'($signed(prod[r][2 * k + 1]));
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < DIM; r++)
        begin
            sum_next[r] = SUM_W'($signed(pair_reg[r][0])) + SUM_W'($signed(pair_reg[r][1]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_valid_reg <= 1'b0;
            sum_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                pair_valid_reg <= in_valid;
            end
            if (sum_ready)
            begin
                sum_valid_reg <= pair_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pair_reg <= pair_next;
        end
        if (sum_ready && pair_valid_reg)
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign sums      = sum_reg;

endmodule

### sv/m4vt_sat_stage.sv
// Last pipeline stage: truncation toward zero, saturation and the output register.
// Depends on m4vt_pkg.
module m4vt_sat_stage
    import m4vt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  sum_vec_t sums,
    output logic     out_valid,
    input  logic     out_ready,
    output res_t     res
);

    logic valid_reg;
    res_t res_reg;
    res_t res_next;
    sum_t biased;
    sum_t quot;
    logic [SUM_W-DATA_W:0] quot_hi;
    logic lane_sat;

    assign in_ready = !valid_reg || out_ready;

    // Negative sums get a bias of one less than the divisor so the shift rounds toward zero.
    always_comb
    begin
        res_next.saturated = 1'b0;
        for (int r = 0; r < DIM; r++)
        begin
            biased   = sums[r] + SUM_W'({FRAC_BITS{sums[r][SUM_W-1]}});
            quot     = biased >>> FRAC_BITS;
            quot_hi  = quot[SUM_W-1:DATA_W-1];
            lane_sat = !((&quot_hi) || !(|quot_hi));
            if (lane_sat)
            begin
                res_next.lanes[r] = quot[SUM_W-1] ? SAT_NEG : SAT_POS;
            end
            else
            begin
                res_next.lanes[r] = quot[DATA_W-1:0];
            end
            res_next.saturated = res_next.saturated | lane_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign res       = res_reg;

endmodule
